[hdl/olist_pkg.sv]
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes for the ordered list engine: item structs, action
// and status codes, and the command that drives the row of list cells.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int ACTION_W      = 3;
   localparam int POS_W         = 8;
   localparam int STATUS_W      = 2;
   localparam int LEN_W         = 5;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_HEAD   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] entry_value;
      logic                      entry_valid;
      logic                      last_result;
      logic [LEN_W-1:0]          list_length;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ROTATE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        keep;
   } cell_ctl_type;

endpackage

[hdl/olist_cell.sv]
// ----------------------------------------------------------------------------
// olist_cell
// One slot of the list. On insert it opens a gap by taking its left
// neighbor; on rotate it takes its right neighbor, and the tail slot takes
// the old head when that entry survives.
// ----------------------------------------------------------------------------
module olist_cell import olist_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  cell_ctl_type                     ctl,
   input  logic [$clog2(DEPTH+1)-1:0]       ins_idx,
   input  logic [$clog2(DEPTH+1)-1:0]       total,
   input  logic signed [VALUE_W-1:0]        ins_value,
   input  logic signed [VALUE_W-1:0]        head_value,
   input  logic signed [VALUE_W-1:0]        left_value,
   input  logic signed [VALUE_W-1:0]        right_value,
   output logic signed [VALUE_W-1:0]        value
);

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] MY_IDX   = CW'(INDEX);
   localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);

   logic signed [VALUE_W-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (MY_IDX == ins_idx) begin
               value_in = ins_value;
            end else if (MY_IDX > ins_idx && MY_IDX <= total) begin
               value_in = left_value;
            end
         end
         CELL_ROTATE: begin
            if (NEXT_IDX < total) begin
               value_in = right_value;
            end else if (NEXT_IDX == total && ctl.keep) begin
               value_in = head_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[hdl/ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values held in a row of cells.
//
//   channel  ports        direction  payload
//   request  req_*        in         action, item_value, position
//   response rsp_*        out        status, entry_value, entry_valid,
//                                    last_result, list_length
//
// Append, head insert and positional insert answer in the cycle after the request
// item: every cell past the insert point shifts toward the tail at once.
// Delete and read-out first load the step count, then take one rotation step per
// entry held when the item came in; delete answers after the last step, read-out
// gives one response item per step.
// Reset clears the state, entry count, step count and response valid only; no clearing pass over the cells.
// A stall on rsp holds the read-out steps and blocks new request items.
// ----------------------------------------------------------------------------
module ordered_list_engine import olist_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(DEPTH+1);
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_CNT  = CW'(1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DEL  = 3'b010,
      ST_READ = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             steps_ff, steps_in;
   logic signed [VALUE_W-1:0] del_value_ff, del_value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   cell_ctl_type              ctl;
   logic [CW-1:0]             ins_idx;
   logic signed [VALUE_W-1:0] cell_val [DEPTH];

   logic                      out_free;
   logic                      accept;
   logic                      full;
   logic                      bad_pos;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= FULL_CNT);
   assign bad_pos   = (req_item.position == '0) ||
                      (PW'(req_item.position) > (PW'(count_ff) + PW'(1)));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      del_value_in = del_value_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl.op       = CELL_HOLD;
      ctl.keep     = 1'b1;
      ins_idx      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STS_OK;
               rsp_in.entry_value = '0;
               rsp_in.entry_valid = 1'b0;
               rsp_in.last_result = 1'b1;
               unique case (req_item.action) inside
                  ACT_APPEND, ACT_HEAD: begin
                     if (full) begin
                        rsp_in.status = STS_FULL;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        ins_idx  = (req_item.action == ACT_APPEND) ? count_ff : '0;
                        count_in = count_ff + ONE_CNT;
                     end
                  end
                  ACT_INSERT: begin
                     if (bad_pos) begin
                        rsp_in.status = STS_RANGE;
                     end else if (full) begin
                        rsp_in.status = STS_FULL;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        ins_idx  = CW'(req_item.position - POS_W'(1));
                        count_in = count_ff + ONE_CNT;
                     end
                  end
                  ACT_DELETE, ACT_READ: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        steps_in     = count_ff;
                        del_value_in = req_item.item_value;
                        state_in     = (req_item.action == ACT_DELETE) ? ST_DEL : ST_READ;
                     end
                  end
                  default: rsp_in.status = STS_OK;
               endcase
               rsp_in.list_length = LEN_W'(count_in);
            end
         end
         ST_DEL: begin
            if (out_free) begin
               ctl.op   = CELL_ROTATE;
               ctl.keep = (cell_val[0] != del_value_ff);
               if (!ctl.keep) begin
                  count_in = count_ff - ONE_CNT;
               end
               steps_in = steps_ff - ONE_CNT;
               if (steps_ff == ONE_CNT) begin
                  state_in           = ST_IDLE;
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = STS_OK;
                  rsp_in.entry_value = '0;
                  rsp_in.entry_valid = 1'b0;
                  rsp_in.last_result = 1'b1;
                  rsp_in.list_length = LEN_W'(count_in);
               end
            end
         end
         ST_READ: begin
            if (out_free) begin
               ctl.op             = CELL_ROTATE;
               ctl.keep           = 1'b1;
               steps_in           = steps_ff - ONE_CNT;
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STS_OK;
               rsp_in.entry_value = cell_val[0];
               rsp_in.entry_valid = 1'b1;
               rsp_in.last_result = (steps_ff == ONE_CNT);
               rsp_in.list_length = LEN_W'(count_ff);
               if (steps_ff == ONE_CNT) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // row of cells, each talks only to its two neighbors and the broadcast
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_val[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_val[i+1];
      end
      olist_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .ins_idx     (ins_idx),
         .total       (count_ff),
         .ins_value   (req_item.item_value),
         .head_value  (cell_val[0]),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_val[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      del_value_ff <= del_value_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (steps_ff != '0 && steps_ff <= count_ff))
      else $error("rotation step count out of step with entry count");

   a_read_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> $stable(count_ff))
      else $error("read-out changed the entry count");

   a_entry_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.entry_valid) |-> (rsp_ff.status == STS_OK))
      else $error("entry item with non-ok status");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for ordered_list_engine. A behavioral copy of the
// list predicts every response item from each accepted request item, and a
// monitor compares the responses field by field, in order. Directed tests
// cover the empty list, filling to capacity and the full-list refusals. A
// long receiver hold-off fills the pipeline, and random traffic runs under
// three idle mixes on the two channels.
// ----------------------------------------------------------------------------
module tb;
   import olist_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;

   // action codes the block treats as no-ops
   localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = ACT_READ + 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   logic signed [VALUE_W-1:0] model_list[$];
   rsp_type                   pending_rsp_q[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;

   ordered_list_engine #(.DEPTH(LIST_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // list predictor
   // ------------------------------------------------------------------
   function automatic void queue_result(logic [STATUS_W-1:0] status,
                                        logic signed [VALUE_W-1:0] value,
                                        logic valid, logic last);
      rsp_type r;
      r.status      = status;
      r.entry_value = value;
      r.entry_valid = valid;
      r.last_result = last;
      r.list_length = LEN_W'(model_list.size());
      pending_rsp_q.push_back(r);
   endfunction

   function automatic void insert_entry(int idx, logic signed [VALUE_W-1:0] value);
      logic signed [VALUE_W-1:0] rebuilt[$];
      for (int i = 0; i < model_list.size(); i++) begin
         if (i == idx) rebuilt.push_back(value);
         rebuilt.push_back(model_list[i]);
      end
      if (idx == model_list.size()) rebuilt.push_back(value);
      model_list = rebuilt;
   endfunction

   function automatic void apply_list_action(req_type it);
      logic signed [VALUE_W-1:0] kept[$];
      int len;
      len = model_list.size();
      case (it.action) inside
         ACT_APPEND, ACT_HEAD: begin
            if (len >= LIST_DEPTH) begin
               queue_result(STS_FULL, '0, 1'b0, 1'b1);
            end else begin
               insert_entry((it.action == ACT_APPEND) ? len : 0, it.item_value);
               queue_result(STS_OK, '0, 1'b0, 1'b1);
            end
         end
         ACT_INSERT: begin
            // range check wins over the full check
            if (it.position == 0 || int'(it.position) > len + 1) begin
               queue_result(STS_RANGE, '0, 1'b0, 1'b1);
            end else if (len >= LIST_DEPTH) begin
               queue_result(STS_FULL, '0, 1'b0, 1'b1);
            end else begin
               insert_entry(int'(it.position) - 1, it.item_value);
               queue_result(STS_OK, '0, 1'b0, 1'b1);
            end
         end
         ACT_DELETE: begin
            if (len == 0) begin
               queue_result(STS_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               foreach (model_list[i])
                  if (model_list[i] !== it.item_value) kept.push_back(model_list[i]);
               model_list = kept;
               queue_result(STS_OK, '0, 1'b0, 1'b1);
            end
         end
         ACT_READ: begin
            if (len == 0) begin
               queue_result(STS_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               foreach (model_list[i])
                  queue_result(STS_OK, model_list[i], 1'b1, (i == len - 1));
            end
         end
         default: queue_result(STS_OK, '0, 1'b0, 1'b1);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   function automatic void compare_field(string name, logic signed [VALUE_W-1:0] want,
                                         logic signed [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (pending_rsp_q.size() == 0) begin
         $error("response item with none outstanding: status %0d value %0d",
                got.status, got.entry_value);
         error_count++;
         return;
      end
      want = pending_rsp_q.pop_front();
      compare_field("status",      VALUE_W'(want.status),      VALUE_W'(got.status));
      compare_field("entry_value", want.entry_value,           got.entry_value);
      compare_field("entry_valid", VALUE_W'(want.entry_valid), VALUE_W'(got.entry_valid));
      compare_field("last_result", VALUE_W'(want.last_result), VALUE_W'(got.last_result));
      compare_field("list_length", VALUE_W'(want.list_length), VALUE_W'(got.list_length));
   endfunction

   // prediction before checking, both on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) apply_list_action(req_item);
         if (rsp_valid && !rsp_stall) check_result(rsp_item);
      end
   end

   always @(negedge clock) begin : recv_drive
      int hold_left;
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic req_type mk_req(logic [ACTION_W-1:0] action,
                                      logic signed [VALUE_W-1:0] value,
                                      logic [POS_W-1:0] pos);
      req_type it;
      it.action     = action;
      it.item_value = value;
      it.position   = pos;
      return it;
   endfunction

   // called and returns at a falling edge; valid stays high for a following item
   task automatic send_item(req_type it);
      logic [63:0] noise;
      while ($urandom_range(99) < send_idle_pct) begin
         noise = {$urandom, $urandom};
         req_valid <= 1'b0;
         req_item  <= noise[$bits(req_type)-1:0];
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (LIST_DEPTH + 8) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] random_value();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 45) return $signed($urandom_range(6)) - 3;   // small pool, many repeats
      if (pick < 50) return 32'sh7fffffff;
      if (pick < 55) return 32'sh80000000;
      return $urandom;
   endfunction

   function automatic req_type random_request();
      req_type     it;
      int unsigned pick;
      int          len;
      len           = model_list.size();
      it.item_value = random_value();
      it.position   = POS_W'($urandom_range(255));
      pick          = $urandom_range(99);
      if (pick < 24) begin
         it.action = ACT_APPEND;
      end else if (pick < 38) begin
         it.action = ACT_HEAD;
      end else if (pick < 60) begin
         it.action = ACT_INSERT;
         if ($urandom_range(9) < 8) it.position = POS_W'($urandom_range(len + 1, 1));
      end else if (pick < 80) begin
         it.action = ACT_DELETE;
         if (len != 0 && $urandom_range(3) != 0)
            it.item_value = model_list[$urandom_range(len - 1)];
      end else if (pick < 95) begin
         it.action = ACT_READ;
      end else begin
         it.action = ACTION_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
      end
      return it;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_empty_list();
      send_item(mk_req(ACT_READ, 0, 0));
      send_item(mk_req(ACT_DELETE, 5, 0));
      send_item(mk_req(ACT_INSERT, 9, 0));
      send_item(mk_req(ACT_INSERT, 9, 8'd255));
      send_item(mk_req(ACT_SPARE_FIRST, 1, 1));
      send_item(mk_req(ACT_SPARE_FIRST + 3'd1, 2, 2));
      send_item(mk_req(ACT_SPARE_LAST, 3, 3));
      wait_idle();
   endtask

   task automatic test_fill_to_capacity();
      logic [ACTION_W-1:0] act;
      send_item(mk_req(ACT_APPEND, 32'sh7fffffff, 0));
      send_item(mk_req(ACT_HEAD, 32'sh80000000, 0));
      send_item(mk_req(ACT_INSERT, 0, 3));                 // right after the tail
      send_item(mk_req(ACT_INSERT, -1, 1));
      for (int i = 4; i < LIST_DEPTH; i++) begin
         act = (i % 3 == 0) ? ACT_APPEND : (i % 3 == 1) ? ACT_HEAD : ACT_INSERT;
         send_item(mk_req(act, (i % 2) ? 7 : i, POS_W'(i / 2)));
      end
      send_item(mk_req(ACT_APPEND, 1, 0));
      send_item(mk_req(ACT_HEAD, 1, 0));
      send_item(mk_req(ACT_INSERT, 1, POS_W'(LIST_DEPTH)));
      send_item(mk_req(ACT_INSERT, 1, POS_W'(LIST_DEPTH + 1)));
      send_item(mk_req(ACT_READ, 0, 0));
      send_item(mk_req(ACT_DELETE, 7, 0));
      wait_idle();
   endtask

   task automatic test_receiver_holdoff();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 300;
      repeat (24) send_item(random_request());
      wait_idle();
   endtask

   task automatic test_random_traffic(int n_items, int send_idle, int recv_idle);
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      repeat (n_items) send_item(random_request());
      wait_idle();
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_fill_to_capacity();
      test_receiver_holdoff();
      test_random_traffic(105, 22, 81);
      test_random_traffic(105, 81, 22);
      test_random_traffic(105, 0, 0);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
hdl/olist_pkg.sv
hdl/olist_cell.sv
hdl/ordered_list_engine.sv
test/tb.sv
